/* rtl/aorc_pkg.sv */
// Shared types and constants for the ADC oversampling accumulator with range check.
// No dependencies; imported by aorc_accum, the top level and the testbench.
package aorc_pkg;

	localparam int unsigned ConvW = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned FillW = 6;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam logic [FillW:0] SumBytes = 7'd2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SAMPLES_PER_SUM = 3'd0,
		CFG_MIN_SUM         = 3'd1,
		CFG_MAX_SUM         = 3'd2,
		CFG_FAULT_LIMIT     = 3'd3,
		CFG_REPORT_BYTES    = 3'd4
	} aorc_cfg_idx_t;

	typedef struct packed {
		logic [CountW-1:0] samples_per_sum;
		logic [ConvW-1:0]  min_sum;
		logic [ConvW-1:0]  max_sum;
		logic [CountW-1:0] fault_limit;
		logic [FillW-1:0]  capacity;
	} aorc_cfg_t;

	typedef struct packed {
		logic step;
		logic clear;
	} aorc_ctrl_t;

	typedef struct packed {
		logic [FillW-1:0] report_length;
		logic             report_end;
		logic             range_fault;
		logic             out_of_range;
		logic [ConvW-1:0] sum;
	} aorc_result_t;

endpackage

/* rtl/aorc_accum.sv */
// Group accumulator, range check, fault run counter and report fill tracking.
// Depends on aorc_pkg for the configuration, control and result types.
module aorc_accum import aorc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  aorc_cfg_t        cfg,
	input  aorc_ctrl_t       ctrl,
	input  logic [ConvW-1:0] conversion,
	output logic             produce,
	output aorc_result_t     result
);

	logic [CountW-1:0] group_pos_q;
	logic [ConvW-1:0]  run_sum_q;
	logic [CountW-1:0] bad_cnt_q;
	logic [FillW-1:0]  fill_q;

	logic              restart;
	logic [ConvW-1:0]  sum_next;
	logic [CountW-1:0] pos_inc;
	logic              bad;
	logic [CountW-1:0] bad_inc;
	logic              fault;
	logic [CountW-1:0] bad_next;
	logic [FillW:0]    fill_add;
	logic              rep_end;
	logic [FillW-1:0]  fill_next;

	always_comb begin
		restart  = (group_pos_q == '0) || (group_pos_q >= cfg.samples_per_sum);
		sum_next = restart ? conversion : run_sum_q + conversion;
		pos_inc  = restart ? CountW'(1) : group_pos_q + CountW'(1);
		produce  = ctrl.step && (pos_inc >= cfg.samples_per_sum);

		bad      = (sum_next < cfg.min_sum) || (sum_next > cfg.max_sum);
		bad_inc  = bad_cnt_q + CountW'(1);
		fault    = bad && (bad_inc >= cfg.fault_limit);
		bad_next = (bad && !fault) ? bad_inc : '0;

		// close the report when one more sum would not fit
		fill_add  = {1'b0, fill_q} + SumBytes;
		rep_end   = (fill_add + SumBytes) > {1'b0, cfg.capacity};
		fill_next = rep_end ? '0 : fill_add[FillW-1:0];

		result.sum           = sum_next;
		result.out_of_range  = bad;
		result.range_fault   = fault;
		result.report_end    = rep_end;
		result.report_length = fill_add[FillW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos_q <= '0;
			run_sum_q   <= '0;
			bad_cnt_q   <= '0;
			fill_q      <= '0;
		end else if (ctrl.clear) begin
			group_pos_q <= '0;
			fill_q      <= '0;
		end else if (ctrl.step) begin
			run_sum_q <= sum_next;
			if (produce) begin
				group_pos_q <= '0;
				bad_cnt_q   <= bad_next;
				fill_q      <= fill_next;
			end else begin
				group_pos_q <= pos_inc;
			end
		end
	end

endmodule

/* rtl/adc_oversample_range_check.sv */
// Top level: configuration registers, input stage, output register and stream handshake.
// Depends on aorc_pkg and aorc_accum.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata[15:0] conversion
//  m_*      | out | m_tvalid/m_tready  | m_tdata sum, out_of_range, range_fault,
//           |     |                    |   report_length; m_tlast report_end
//  cfg_*    | in  | cfg_we (no wait)   | cfg_index selects register, cfg_data value
//
// One word is accepted per cycle unless the output stalls; the last conversion of a group passes
// the input stage, then its result word is loaded into the output register and presented.
// The accumulator add followed by the min/max compares sets the clock path.
// A stalled output holds the input stage; the input stage still refills while
// the output word waits, so one word in each register keeps the stream moving.
// Reset clears all control state and loads the register reset values.
module adc_oversample_range_check import aorc_pkg::*; #(
	parameter int unsigned REPORT_CAPACITY = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	// conversion from the converter interface
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [15:0] conversion
	// completed sums
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,   // [15:0] sum, [16] out_of_range,
	                                       // [17] range_fault, [23:18] report_length
	output logic                m_tlast,   // report_end
	// register writes
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam logic [7:0] CapLimit = REPORT_CAPACITY[7:0];

	// configuration registers
	logic [CountW-1:0] samples_per_sum_q;
	logic [ConvW-1:0]  min_sum_q;
	logic [ConvW-1:0]  max_sum_q;
	logic [CountW-1:0] fault_limit_q;
	logic [FillW-1:0]  report_bytes_q;

	// input stage and output register
	logic              valid_s1;
	logic [ConvW-1:0]  conv_s1;
	logic              out_valid_q;
	aorc_result_t      out_q;

	logic              advance_s1;
	logic [FillW-1:0]  capacity;
	aorc_cfg_t         cfg;
	aorc_ctrl_t        ctrl;
	logic              produce;
	aorc_result_t      result;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_per_sum_q <= '0;
			min_sum_q         <= '0;
			max_sum_q         <= '1;
			fault_limit_q     <= '0;
			report_bytes_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLES_PER_SUM: samples_per_sum_q <= cfg_data[CountW-1:0];
				CFG_MIN_SUM:         min_sum_q         <= cfg_data[ConvW-1:0];
				CFG_MAX_SUM:         max_sum_q         <= cfg_data[ConvW-1:0];
				CFG_FAULT_LIMIT:     fault_limit_q     <= cfg_data[CountW-1:0];
				CFG_REPORT_BYTES:    report_bytes_q    <= cfg_data[FillW-1:0];
				default: ;
			endcase
		end
	end

	// clamp the report size to what the design supports
	always_comb begin
		capacity = ({2'b00, report_bytes_q} > CapLimit) ? CapLimit[FillW-1:0] : report_bytes_q;
		cfg.samples_per_sum = samples_per_sum_q;
		cfg.min_sum         = min_sum_q;
		cfg.max_sum         = max_sum_q;
		cfg.fault_limit     = fault_limit_q;
		cfg.capacity        = capacity;
	end

	// advance the input stage when the output register is free or being drained
	assign advance_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;

	// a zero group size drops conversions without touching state
	assign ctrl.step  = advance_s1 && (samples_per_sum_q != '0);
	assign ctrl.clear = cfg_we && ((cfg_index == CFG_SAMPLES_PER_SUM) ||
		(cfg_index == CFG_REPORT_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			conv_s1 <= s_tdata;
		end
	end

	aorc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctrl       (ctrl),
		.conversion (conv_s1),
		.produce    (produce),
		.result     (result)
	);

	// output register: load a finished sum, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.report_length, out_q.range_fault, out_q.out_of_range, out_q.sum};
	assign m_tlast  = out_q.report_end;

endmodule

/* rtl/aorc_checker.sv */
// Port-level checks for adc_oversample_range_check, attached by bind.
// Depends only on the port list of the top level.
module aorc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled word
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("m_tdata changed while stalled");

	// a fault is only raised on an out-of-range sum
	a_fault_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[16])
		else $error("range_fault without out_of_range");

	// every sum adds two bytes, so the length is even and nonzero
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18] == 1'b0) && (m_tdata[23:18] != 6'd0))
		else $error("bad report_length");

	// with the output empty the input stage can always move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low with an empty output");

endmodule

bind adc_oversample_range_check aorc_checker u_aorc_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for adc_oversample_range_check: stream driver, stream monitor and a
// cycle-free predictor of sums, range flags, fault flags and report framing.
// Depends on aorc_pkg and the RTL of the block; needs no other file.
module tb;
	import aorc_pkg::*;

	// Same capacity as the instance below; the predictor clamps report_bytes to it.
	localparam int unsigned REPORT_CAPACITY = 48;
	localparam int unsigned SUM_BYTES = 2;
	// A result passes the input stage, then the output register, after its last conversion; wait
	// well past that before touching registers: a partial group can still sit in the input stage.
	localparam int unsigned IDLE_CYCLES = 8;
	// Long receiver hold-off, long enough to fill both pipeline registers and back up s_tready.
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned MAX_REPORTED = 10;
	// Register indexes with no register behind them; writes there must change nothing.
	localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 3'd7;

	typedef enum int unsigned {
		RX_OPEN,
		RX_CHOPPY,
		RX_CHOKED
	} rx_mode_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata   = '0;   // [15:0] conversion
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [23:0]         m_tdata;          // [15:0] sum, [16] out_of_range, [17] range_fault,
	                                       // [23:18] report_length
	logic                m_tlast;          // report_end
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;

	adc_oversample_range_check #(
		.REPORT_CAPACITY(REPORT_CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor copy of the register file.
	logic [7:0]  cfg_samples;
	logic [15:0] cfg_min;
	logic [15:0] cfg_max;
	logic [7:0]  cfg_fault_limit;
	logic [5:0]  cfg_report_bytes;

	// Predictor copy of the block state.
	logic [7:0]  grp_pos;
	logic [15:0] grp_sum;
	logic [7:0]  bad_run;
	logic [5:0]  rpt_fill;

	logic [15:0]  conv_pending_q[$];   // conversions waiting for the driver
	aorc_result_t sum_expect_q[$];     // predicted sums, oldest first

	int unsigned conv_queued   = 0;
	int unsigned conv_accepted = 0;
	int unsigned fail_count    = 0;
	int unsigned hold_req      = 0;    // bumped by the stimulus to ask for a long hold-off

	// Driver burst state.
	int unsigned burst_left;
	int unsigned gap_left;

	// Receiver stall state.
	rx_mode_t    rx_mode;
	int unsigned rx_left;
	int unsigned hold_left;
	int unsigned hold_seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the stream wedges.
	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Register write as the block sees it. Writes to the group count or the report size restart
	// the group and empty the report; the out-of-range run survives every write.
	task automatic apply_register_write(input logic [CfgIdxW-1:0] idx,
	                                    input logic [CfgDataW-1:0] val);
		case (idx)
			CFG_SAMPLES_PER_SUM: begin
				cfg_samples = val[7:0];
				grp_pos = '0;
				rpt_fill = '0;
			end
			CFG_MIN_SUM: cfg_min = val;
			CFG_MAX_SUM: cfg_max = val;
			CFG_FAULT_LIMIT: cfg_fault_limit = val[7:0];
			CFG_REPORT_BYTES: begin
				cfg_report_bytes = val[5:0];
				grp_pos = '0;
				rpt_fill = '0;
			end
			default: ;
		endcase
	endtask

	// Fold one accepted conversion into the group; on a completed group queue the expected sum.
	task automatic accumulate_conversion(input logic [15:0] conv);
		aorc_result_t res;
		int unsigned  cap;
		int unsigned  len;
		// A disabled block ignores the word and keeps its state.
		if (cfg_samples == 0)
			return;
		if (grp_pos == 0 || grp_pos >= cfg_samples) begin
			grp_sum = conv;
			grp_pos = 8'd1;
		end else begin
			grp_sum = grp_sum + conv;    // wraps at 16 bits
			grp_pos = grp_pos + 8'd1;
		end
		if (grp_pos < cfg_samples)
			return;
		grp_pos = '0;

		res = '0;
		res.sum = grp_sum;
		if (grp_sum < cfg_min || grp_sum > cfg_max) begin
			res.out_of_range = 1'b1;
			bad_run = bad_run + 8'd1;
			// A zero limit faults on every out-of-range sum.
			if (bad_run >= cfg_fault_limit) begin
				res.range_fault = 1'b1;
				bad_run = '0;
			end
		end else begin
			bad_run = '0;
		end

		// Oversized report sizes clamp to the capacity; below four bytes every sum closes
		// a two-byte report.
		cap = (cfg_report_bytes > REPORT_CAPACITY) ? REPORT_CAPACITY : cfg_report_bytes;
		len = rpt_fill + SUM_BYTES;
		res.report_length = len[5:0];
		if (len + SUM_BYTES > cap) begin
			res.report_end = 1'b1;
			rpt_fill = '0;
		end else begin
			rpt_fill = len[5:0];
		end
		sum_expect_q.push_back(res);
	endtask

	// Pulse one register write; the predictor takes it at once since the block is idle.
	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_register_write(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_conversion(input logic [15:0] conv);
		conv_pending_q.push_back(conv);
		conv_queued++;
	endtask

	// Hold the sender until every queued word is taken and every expected sum is back,
	// then let the pipeline run dry.
	task automatic settle();
		while (conv_accepted != conv_queued)
			@(posedge clk);
		while (sum_expect_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	// Driver: offer words in bursts of random length with random gaps; hold a word until taken.
	always @(posedge clk or negedge arst_n) begin : drive
		int unsigned pick;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (conv_pending_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= conv_pending_q.pop_front();
				if (burst_left <= 1) begin
					// Pick the next burst: now and then a long one with no gap at all.
					pick = $urandom_range(0, 3);
					if (pick == 0) begin
						burst_left <= $urandom_range(40, 80);
						gap_left <= 0;
					end else begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= $urandom_range(1, 8);
					end
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall on a pattern of its own, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin : receive
		logic ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			ready_next = 1'b1;
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				ready_next = 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				ready_next = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode <= rx_mode_t'($urandom_range(0, 2));
					rx_left <= $urandom_range(5, 60);
				end else begin
					rx_left <= rx_left - 1;
				end
				case (rx_mode)
					RX_OPEN:   ready_next = 1'b1;
					RX_CHOPPY: ready_next = ($urandom_range(0, 1) == 0);
					RX_CHOKED: ready_next = ($urandom_range(0, 7) == 0);
					default:   ready_next = 1'b1;
				endcase
			end
			m_tready <= ready_next;
		end
	end

	// Monitor: check a taken result word against the oldest prediction, then fold in a taken
	// conversion. Checking first keeps a new prediction from matching a stray word.
	always @(posedge clk) begin : watch
		aorc_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (sum_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTED)
						$display("unexpected result word: tdata=%h tlast=%b", m_tdata, m_tlast);
				end else begin
					want = sum_expect_q.pop_front();
					if (m_tdata[15:0] !== want.sum || m_tdata[16] !== want.out_of_range ||
					    m_tdata[17] !== want.range_fault || m_tlast !== want.report_end ||
					    m_tdata[23:18] !== want.report_length) begin
						fail_count++;
						if (fail_count <= MAX_REPORTED)
							$display({"result mismatch: expected sum=%h oor=%b fault=%b end=%b ",
							          "len=%0d, got sum=%h oor=%b fault=%b end=%b len=%0d"},
							         want.sum, want.out_of_range, want.range_fault,
							         want.report_end, want.report_length,
							         m_tdata[15:0], m_tdata[16], m_tdata[17], m_tlast,
							         m_tdata[23:18]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				accumulate_conversion(s_tdata);
				conv_accepted++;
			end
		end
	end

	initial begin : stimulus
		int unsigned     spc;
		int unsigned     n;
		int unsigned     phase;
		int unsigned     random_sent;
		int unsigned     conv_span;
		logic [15:0]     lo;
		logic [15:0]     hi;
		logic [CfgDataW-1:0] data;

		// Register reset values and cleared state.
		cfg_samples = '0;
		cfg_min = '0;
		cfg_max = 16'hFFFF;
		cfg_fault_limit = '0;
		cfg_report_bytes = '0;
		grp_pos = '0;
		grp_sum = '0;
		bad_run = '0;
		rpt_fill = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset: both words are dropped with no result.
		send_conversion(16'hFFFF);
		send_conversion(16'h0000);
		settle();

		// One conversion per sum, tiny report, zero fault limit: every out-of-range sum faults
		// and every sum closes its own report. Upper data bits must be dropped.
		cfg_write(CFG_SAMPLES_PER_SUM, 16'hFF01);
		cfg_write(CFG_REPORT_BYTES, 16'h0002);
		cfg_write(CFG_MIN_SUM, 16'h0100);
		cfg_write(CFG_MAX_SUM, 16'hFF00);
		cfg_write(CFG_FAULT_LIMIT, 16'hFF00);
		send_conversion(16'h0000);
		send_conversion(16'hFFFF);
		send_conversion(16'h8000);
		send_conversion(16'h00FF);
		send_conversion(16'hFF01);
		settle();

		// Pairs with wrap-around, an oversized report and a fault after two bad sums in a row.
		cfg_write(CFG_SAMPLES_PER_SUM, 16'h0002);
		cfg_write(CFG_FAULT_LIMIT, 16'h0002);
		cfg_write(CFG_REPORT_BYTES, 16'hFFFF);
		cfg_write(CFG_MIN_SUM, 16'h1000);
		cfg_write(CFG_MAX_SUM, 16'h2000);
		send_conversion(16'hFFFF);
		send_conversion(16'hFFFF);
		send_conversion(16'h0800);
		send_conversion(16'h0800);
		send_conversion(16'h0000);
		send_conversion(16'h0000);
		send_conversion(16'h1000);
		send_conversion(16'h1000);
		send_conversion(16'hFFFF);
		send_conversion(16'h0001);
		send_conversion(16'h0000);
		send_conversion(16'h0000);
		settle();

		// Inverted range marks every sum bad; the largest limit never faults here. Writes to
		// unmapped indexes in the middle of a group must not restart it.
		cfg_write(CFG_SAMPLES_PER_SUM, 16'h0003);
		cfg_write(CFG_REPORT_BYTES, 16'h0005);
		cfg_write(CFG_FAULT_LIMIT, 16'h01FF);
		cfg_write(CFG_MIN_SUM, 16'hFFFF);
		cfg_write(CFG_MAX_SUM, 16'h0000);
		send_conversion(16'h1234);
		send_conversion(16'hABCD);
		settle();
		cfg_write(CFG_UNMAPPED_LO, 16'hFFFF);
		cfg_write(CFG_UNMAPPED_HI, 16'h0000);
		send_conversion(16'h5555);
		send_conversion(16'hAAAA);
		send_conversion(16'h0F0F);
		send_conversion(16'hF0F0);
		settle();

		// Random phases. The first uses the largest group once; the second asks the receiver
		// for a long hold-off while one-word groups keep coming, so the block backs up.
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (phase == 0)
				spc = 255;
			else if (phase == 1)
				spc = 1;
			else if ($urandom_range(0, 3) == 0)
				spc = $urandom_range(4, 12);
			else
				spc = $urandom_range(1, 3);
			data = 16'($urandom);
			data[7:0] = spc[7:0];
			cfg_write(CFG_SAMPLES_PER_SUM, data);

			data = 16'($urandom);
			case ($urandom_range(0, 7))
				0: data[5:0] = 6'd0;
				1: data[5:0] = 6'd2;
				2: data[5:0] = 6'd3;
				3: data[5:0] = 6'd4;
				4: data[5:0] = 6'd48;
				5: data[5:0] = 6'd63;
				default: data[5:0] = 6'($urandom_range(0, 63));
			endcase
			cfg_write(CFG_REPORT_BYTES, data);

			data = 16'($urandom);
			case ($urandom_range(0, 5))
				0: data[7:0] = 8'd0;
				1: data[7:0] = 8'd1;
				2: data[7:0] = 8'd2;
				3: data[7:0] = 8'd255;
				default: data[7:0] = 8'($urandom_range(0, 4));
			endcase
			cfg_write(CFG_FAULT_LIMIT, data);

			case ($urandom_range(0, 4))
				0: begin
					lo = 16'h0000;
					hi = 16'hFFFF;
				end
				1: begin
					lo = 16'($urandom_range(0, 16'h7FFF));
					hi = lo + 16'($urandom_range(0, 16'h8000));
				end
				2: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				3: begin
					lo = 16'($urandom);
					hi = lo;
				end
				default: begin
					lo = 16'h4000;
					hi = 16'hC000;
				end
			endcase
			cfg_write(CFG_MIN_SUM, lo);
			cfg_write(CFG_MAX_SUM, hi);
			if ($urandom_range(0, 4) == 0)
				cfg_write(CFG_UNMAPPED_LO + CfgIdxW'($urandom_range(0, 2)), 16'($urandom));

			if (phase == 0) begin
				n = 255;
			end else if (phase == 1) begin
				n = 48;
				hold_req++;
			end else begin
				// Leave a partial group behind now and then; the next phase restarts it.
				n = spc * $urandom_range(4, 14) + $urandom_range(0, spc - 1);
				// Stop near the item budget.
				if (n > RANDOM_ITEMS - random_sent)
					n = RANDOM_ITEMS - random_sent;
			end
			// Small conversions keep sums from wrapping so the range window gets hit.
			conv_span = ($urandom_range(0, 1) == 0) ? 65535 : 65535 / spc;
			for (int i = 0; i < n; i++)
				send_conversion(16'($urandom_range(0, conv_span)));
			random_sent += n;
			phase++;
			settle();
		end

		if (fail_count == 0 && sum_expect_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
